// ----- hdl/bcd_multiplexed_digit_driver_assert.svh -----
// Assertion macros used by the digit scanner module
`ifndef BCD_MULTIPLEXED_DIGIT_DRIVER_ASSERT_SVH
`define BCD_MULTIPLEXED_DIGIT_DRIVER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BMDD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BMDD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/bmdd_pkg.sv -----
// Shared constants and types of the multiplexed BCD digit driver
package bmdd_pkg;

	localparam int MAX_DIGITS   = 10;
	localparam int DIG_W        = 4;
	localparam int BCD_W        = DIG_W * MAX_DIGITS;
	localparam int VAL_W        = 32;
	localparam int BITS_PER_STG = 4;
	localparam int NSTG         = VAL_W / BITS_PER_STG;
	localparam int CNT_W        = 4;
	localparam int Q_DEPTH      = 2;
	localparam int Q_PTR_W      = 1;
	localparam int Q_CNT_W      = 2;

	localparam logic [CNT_W-1:0] DIGIT_COUNT_RST = CNT_W'(3);
	localparam logic [CNT_W-1:0] DIGIT_COUNT_MIN = CNT_W'(1);
	localparam logic [CNT_W-1:0] DIGIT_COUNT_MAX = CNT_W'(MAX_DIGITS);

	typedef logic [BCD_W-1:0] bcd_t;
	typedef logic [DIG_W-1:0] digit_t;
	typedef logic [VAL_W-1:0] value_t;
	typedef logic [CNT_W-1:0] count_t;

endpackage

// ----- hdl/bmdd_conv.sv -----
// Front end: pipelined binary to BCD conversion, four bits per stage
module bmdd_conv (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bmdd_pkg::value_t value,
	output logic            q_valid,
	input  logic            q_ready,
	output bmdd_pkg::bcd_t  q_data
);
	import bmdd_pkg::*;

	logic [NSTG-1:0] vld_s;
	bcd_t            bcd_s [NSTG];
	value_t          bin_s [NSTG];
	logic [NSTG-1:0] adv;
	logic [NSTG-1:0] nxt_vld;
	bcd_t            nxt_bcd [NSTG];
	value_t          nxt_bin [NSTG];

	function automatic bcd_t dabble4(input bcd_t bcd_in, input logic [BITS_PER_STG-1:0] bits);
		bcd_t   acc;
		digit_t dig;
		acc = bcd_in;
		for (int b = BITS_PER_STG - 1; b >= 0; b--) begin
			for (int d = 0; d < MAX_DIGITS; d++) begin
				dig = acc[d*DIG_W +: DIG_W];
				if (dig >= DIG_W'(5)) begin
					acc[d*DIG_W +: DIG_W] = dig + DIG_W'(3);
				end
			end
			acc = {acc[BCD_W-2:0], bits[b]};
		end
		return acc;
	endfunction

	always_comb begin
		adv[NSTG-1] = !vld_s[NSTG-1] || q_ready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	always_comb begin
		nxt_vld[0] = in_valid;
		nxt_bcd[0] = dabble4('0, value[VAL_W-1 -: BITS_PER_STG]);
		nxt_bin[0] = value << BITS_PER_STG;
		for (int i = 1; i < NSTG; i++) begin
			nxt_vld[i] = vld_s[i-1];
			nxt_bcd[i] = dabble4(bcd_s[i-1], bin_s[i-1][VAL_W-1 -: BITS_PER_STG]);
			nxt_bin[i] = bin_s[i-1] << BITS_PER_STG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int i = 0; i < NSTG; i++) begin
				if (adv[i]) begin
					vld_s[i] <= nxt_vld[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NSTG; i++) begin
			if (adv[i]) begin
				bcd_s[i] <= nxt_bcd[i];
				bin_s[i] <= nxt_bin[i];
			end
		end
	end

	assign in_ready = adv[0];
	assign q_valid  = vld_s[NSTG-1];
	assign q_data   = bcd_s[NSTG-1];

endmodule

// ----- hdl/bmdd_fifo.sv -----
// Short queue between the converter and the digit scanner
module bmdd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  bmdd_pkg::bcd_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output bmdd_pkg::bcd_t rd_data
);
	import bmdd_pkg::*;

	bcd_t                 mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 push;
	logic                 pop;

	assign wr_ready = cnt_q != Q_CNT_W'(Q_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- hdl/bmdd_scan.sv -----
// Back end: scans the kept digits of one number out, most significant first
`include "bcd_multiplexed_digit_driver_assert.svh"

module bmdd_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  bmdd_pkg::count_t digit_count,
	input  logic             q_valid,
	output logic             q_ready,
	input  bmdd_pkg::bcd_t   q_data,
	output logic             out_valid,
	input  logic             out_ready,
	output bmdd_pkg::digit_t bcd_lines,
	output bmdd_pkg::count_t digit_select,
	output logic             last
);
	import bmdd_pkg::*;

	count_t k_q;
	logic   out_valid_q;
	digit_t bcd_q;
	count_t sel_q;
	logic   last_q;
	logic   load;
	logic   is_last;
	count_t pos;
	digit_t digs [MAX_DIGITS];

	always_comb begin
		for (int d = 0; d < MAX_DIGITS; d++) begin
			digs[d] = q_data[d*DIG_W +: DIG_W];
		end
	end

	assign load    = !out_valid_q || out_ready;
	assign is_last = k_q == (digit_count - 1'b1);
	assign pos     = digit_count - 1'b1 - k_q;
	assign q_ready = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else if (load) begin
			out_valid_q <= q_valid;
			if (q_valid) begin
				k_q <= is_last ? '0 : k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_valid) begin
			bcd_q  <= digs[pos];
			sel_q  <= k_q;
			last_q <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign bcd_lines    = bcd_q;
	assign digit_select = sel_q;
	assign last         = last_q;

	`BMDD_ASSERT_IMP(a_sel_range, out_valid, digit_select < digit_count,
		"digit index beyond digit count")
	`BMDD_ASSERT_IMP(a_last_pos, out_valid && last, digit_select == digit_count - 1'b1,
		"last flag not on final digit")
	`BMDD_ASSERT_IMP(a_bcd_range, out_valid, bcd_lines <= DIG_W'(9),
		"BCD digit out of range")
	`BMDD_ASSERT_NXT(a_pop_last, q_valid && q_ready, out_valid && last,
		"number released without its final digit")

endmodule

// ----- hdl/bcd_multiplexed_digit_driver.sv -----
// Top level of the multiplexed BCD digit driver
// Each 32-bit number is converted to decimal in an eight-stage pipeline (four
// bits per stage) and lands in a two-entry queue; the scanner then emits the
// lowest digit_count digits, one per cycle while out_ready is high, most
// significant first, with the last digit flagged. Sustained throughput is set
// by the single digit output port; the converter takes a new number every
// cycle while the queue and its stages have room. digit_count writes are
// clamped to 1..10.
module bcd_multiplexed_digit_driver (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  bmdd_pkg::count_t  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  bmdd_pkg::value_t  value,
	output logic              out_valid,
	input  logic              out_ready,
	output bmdd_pkg::digit_t  bcd_lines,
	output bmdd_pkg::count_t  digit_select,
	output logic              last
);
	import bmdd_pkg::*;

	count_t digit_count_q;
	count_t cfg_clamped;
	logic   cq_valid;
	logic   cq_ready;
	bcd_t   cq_data;
	logic   sq_valid;
	logic   sq_ready;
	bcd_t   sq_data;

	assign cfg_ready = 1'b1;

	always_comb begin
		cfg_clamped = cfg_data;
		if (cfg_data < DIGIT_COUNT_MIN) begin
			cfg_clamped = DIGIT_COUNT_MIN;
		end else if (cfg_data > DIGIT_COUNT_MAX) begin
			cfg_clamped = DIGIT_COUNT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= DIGIT_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			digit_count_q <= cfg_clamped;
		end
	end

	bmdd_conv u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.q_valid  (cq_valid),
		.q_ready  (cq_ready),
		.q_data   (cq_data)
	);

	bmdd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cq_valid),
		.wr_ready (cq_ready),
		.wr_data  (cq_data),
		.rd_valid (sq_valid),
		.rd_ready (sq_ready),
		.rd_data  (sq_data)
	);

	bmdd_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.digit_count  (digit_count_q),
		.q_valid      (sq_valid),
		.q_ready      (sq_ready),
		.q_data       (sq_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bcd_lines    (bcd_lines),
		.digit_select (digit_select),
		.last         (last)
	);

endmodule

// ----- sim/bcd_multiplexed_digit_driver_tb.sv -----
// Testbench for the multiplexed BCD digit driver: directed and random numbers and digit counts, scoreboard check
`timescale 1ns / 1ps

module bcd_multiplexed_digit_driver_tb;
	import bmdd_pkg::*;

	typedef struct packed {
		digit_t bcd;
		count_t sel;
		logic   last;
	} digit_rec_t;

	class digit_scoreboard;
		digit_rec_t expected_digits[$];
		count_t     digit_count;
		int         errors;

		function new();
			digit_count = DIGIT_COUNT_RST;
			errors = 0;
		endfunction

		function int shown_digits();
			int n;
			n = digit_count;
			if (n < 1) n = 1;
			if (n > MAX_DIGITS) n = MAX_DIGITS;
			return n;
		endfunction

		function int pending();
			return expected_digits.size();
		endfunction

		// expected digits of an accepted number, most significant first
		function void note_value(value_t v);
			bit [31:0] rem;
			digit_t    digs[MAX_DIGITS];
			int        n;
			digit_rec_t rec;
			n = shown_digits();
			rem = v;
			for (int k = n - 1; k >= 0; k--) begin
				digs[k] = digit_t'(rem % 10);
				rem = rem / 10;
			end
			for (int k = 0; k < n; k++) begin
				rec.bcd = digs[k];
				rec.sel = count_t'(k);
				rec.last = (k == n - 1);
				expected_digits.push_back(rec);
			end
		endfunction

		function void check_digit(digit_t bcd, count_t sel, logic last);
			digit_rec_t exp_rec;
			if (expected_digits.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected digit bcd=%0d sel=%0d last=%0b",
						$realtime, bcd, sel, last);
				return;
			end
			exp_rec = expected_digits.pop_front();
			if (exp_rec.bcd !== bcd || exp_rec.sel !== sel || exp_rec.last !== last) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch exp bcd=%0d sel=%0d last=%0b got %0d %0d %0b",
						$realtime, exp_rec.bcd, exp_rec.sel, exp_rec.last,
						bcd, sel, last);
			end
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cfg_valid = 1'b0;
	logic   cfg_ready;
	count_t cfg_data = '0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	value_t value = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	digit_t bcd_lines;
	count_t digit_select;
	logic   last;

	digit_scoreboard sb = new();
	bit calm = 1'b0;

	bcd_multiplexed_digit_driver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bcd_lines    (bcd_lines),
		.digit_select (digit_select),
		.last         (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#30_000_000;
		$display("bcd_multiplexed_digit_driver_tb: done, errors");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic bit [31:0] pow10(int e);
		bit [31:0] p;
		p = 1;
		repeat (e) p = p * 10;
		return p;
	endfunction

	function automatic value_t rand_value();
		int sel;
		sel = $urandom_range(0, 5);
		case (sel)
			0: return $urandom_range(0, 999);
			1: return pow10($urandom_range(1, 9)) + $urandom_range(0, 2) - 1;
			2: return pow10($urandom_range(1, 9)) - 1;
			3: return $urandom >> $urandom_range(0, 31);
			4: return 32'hFFFF_FFFF - $urandom_range(0, 20);
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_digit(bcd_lines, digit_select, last);

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			g = pick_gap();
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	task automatic send_value(value_t v, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_value(v);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(count_t d);
		cfg_valid <= 1'b1;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.digit_count = d;
	endtask

	initial begin
		value_t directed[$];
		count_t counts[$];
		int per_phase;

		directed = {32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999,
			32'd1000, 32'd999999999, 32'd1000000000, 32'd1234567890, 32'h8000_0000,
			32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
		counts = {4'd1, 4'd10, 4'd0, 4'd15, 4'd3, 4'd7, 4'd2, 4'd11,
			4'd5, 4'd9, 4'd4, 4'd14};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full width, all digits
		write_count(4'd10);
		foreach (directed[i]) send_value(directed[i], pick_gap());
		drain();
		// zero count shows units only
		write_count(4'd0);
		send_value(32'd7, 0);
		send_value(32'hFFFF_FFFF, 0);
		drain();
		// count above ten saturates
		write_count(4'd15);
		send_value(32'hFFFF_FFFF, 0);
		send_value(32'd0, 0);
		drain();

		per_phase = 39;
		foreach (counts[p]) begin
			write_count(counts[p]);
			calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < per_phase; i++) begin
				if (p == 5 && i == per_phase / 2)
					drain();
				send_value(rand_value(), pick_gap());
			end
			drain();
		end
		calm = 1'b0;

		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("bcd_multiplexed_digit_driver_tb: done, clean");
		else
			$display("bcd_multiplexed_digit_driver_tb: done, errors");
		$finish;
	end

endmodule
